[rtl/core/smkr_pkg.sv]
// ----------------------------------------------------------------------------
// smkr_pkg
// Shared types and codes of the sticky modifier / key repeat core.
// ----------------------------------------------------------------------------
package smkr_pkg;

   // timers
   localparam int TmrW = 16;

   // modifiers
   localparam int NumMods  = 5;
   localparam int NumSyms  = 4;            // modifiers that carry a keysym
   localparam int FnMod    = 4;
   localparam int ShiftMod = 0;

   // modifier states
   localparam logic [1:0] ModOff     = 2'd0;
   localparam logic [1:0] ModOneShot = 2'd1;
   localparam logic [1:0] ModLocked  = 2'd2;

   // event modes
   localparam logic [1:0] ModePress   = 2'd0;
   localparam logic [1:0] ModeRelease = 2'd1;
   localparam logic [1:0] ModeTick    = 2'd2;

   // key kinds
   localparam logic [1:0] KindSpacer   = 2'd0;
   localparam logic [1:0] KindModifier = 2'd1;
   localparam logic [1:0] KindChar     = 2'd2;
   localparam logic [1:0] KindAction   = 2'd3;

   // result actions
   localparam logic [1:0] ActStatus = 2'd0;
   localparam logic [1:0] ActDown   = 2'd1;
   localparam logic [1:0] ActTap    = 2'd2;
   localparam logic [1:0] ActUp     = 2'd3;

   // control register indexes
   localparam logic [2:0] CsrShiftSym   = 3'd0;
   localparam logic [2:0] CsrControlSym = 3'd1;
   localparam logic [2:0] CsrAltSym     = 3'd2;
   localparam logic [2:0] CsrSuperSym   = 3'd3;
   localparam logic [2:0] CsrLongPress  = 3'd4;
   localparam logic [2:0] CsrStickyTo   = 3'd5;
   localparam logic [2:0] CsrRptDelay   = 3'd6;
   localparam logic [2:0] CsrRptIntv    = 3'd7;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  key_kind;
      logic [2:0]  mod_index;
      logic [31:0] sym_code;
      logic [31:0] shifted_code;
      logic [31:0] fn_code;
      logic        repeat_enable;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  action_kind;
      logic [31:0] keysym;
      logic        state_changed;
      logic [9:0]  modifier_states;
      logic        from_repeat;
      logic        last;
   } rsp_word_type;

endpackage

[rtl/core/sticky_modifier_key_repeat_core.sv]
// ----------------------------------------------------------------------------
// sticky_modifier_key_repeat_core
// Keyboard front end: sticky modifiers with long-press lock and one-shot
// expiry, and typematic repeat of character keys. Each event word is turned
// into a script of down, tap and up words.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------
//   req     | in        | req_valid/req_ready | req_word_type
//   rsp     | out       | rsp_valid/rsp_ready | rsp_word_type
//   csr     | in        | csr_write_en        | csr_index, csr_wdata
//
// An event is registered, then evaluated combinationally against the modifier
// and timer state, which loads a script buffer. The buffer hands out one
// result word per cycle while rsp_ready is high; a script has 1 to 9 words
// (2*held+1 for a tap), and events with no result load no words.
// The next event is evaluated in the cycle the last word is taken. A stall
// on rsp holds the buffer and, once the input register is full, req_ready.
// Reset is synchronous and loads the register defaults.
// ----------------------------------------------------------------------------
module sticky_modifier_key_repeat_core
   import smkr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_write_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam logic [32:0]     TmrMaxWide = 33'((64'd1 << TmrW) - 64'd1);
   localparam logic [TmrW-1:0] TmrMax     = TmrMaxWide[TmrW-1:0];

   // saturating timer increment
   function automatic logic [TmrW-1:0] tmr_inc(input logic [TmrW-1:0] cnt);
      tmr_inc = (cnt == TmrMax) ? cnt : cnt + TmrW'(1);
   endfunction

   // timer limit: register value clamped to [1, TmrMax]
   function automatic logic [TmrW-1:0] tmr_limit(input logic [15:0] r);
      logic [32:0] wide;
      wide = {17'd0, r};
      if (wide > TmrMaxWide) begin
         tmr_limit = TmrMax;
      end else if (r == 16'd0) begin
         tmr_limit = TmrW'(1);
      end else begin
         tmr_limit = wide[TmrW-1:0];
      end
   endfunction

   // control registers
   logic [31:0] mod_sym_ff [NumSyms];
   logic [15:0] long_press_ff, sticky_to_ff, rpt_delay_ff, rpt_intv_ff;

   // modifier state
   logic [1:0]      mod_state_ff [NumMods];
   logic [1:0]      mod_state_in [NumMods];
   logic            lp_fired_ff  [NumMods];
   logic            lp_fired_in  [NumMods];
   logic [TmrW-1:0] hold_cnt_ff  [NumMods];
   logic [TmrW-1:0] hold_cnt_in  [NumMods];
   logic            hold_run_ff  [NumMods];
   logic            hold_run_in  [NumMods];
   logic [TmrW-1:0] exp_cnt_ff   [NumMods];
   logic [TmrW-1:0] exp_cnt_in   [NumMods];
   logic            exp_run_ff   [NumMods];
   logic            exp_run_in   [NumMods];

   // repeat state
   logic [31:0]     rpt_base_ff, rpt_base_in;
   logic [31:0]     rpt_shf_ff, rpt_shf_in;
   logic [31:0]     rpt_fn_ff, rpt_fn_in;
   logic            rpt_run_ff, rpt_run_in;
   logic            rpt_started_ff, rpt_started_in;
   logic [TmrW-1:0] rpt_cnt_ff, rpt_cnt_in;

   // input register
   req_word_type in_ff;
   logic         in_vld_ff, in_vld_in;

   // script buffer
   logic [31:0] held_ff [NumSyms];
   logic [31:0] held_in [NumSyms];
   logic [2:0]  nheld_ff, nheld_in;
   logic [31:0] target_ff, target_in;
   logic [3:0]  last_idx_ff, last_idx_in;
   logic [3:0]  idx_ff;
   logic        status_ff, status_in;
   logic        changed_ff, changed_in;
   logic [9:0]  states_ff, states_in;
   logic        from_rep_ff, from_rep_in;
   logic        buf_vld_ff;

   // handshake
   logic rsp_fire, rsp_last, proc, emit, tap;
   logic [31:0] tap_base, tap_shf, tap_fn;
   logic [2:0]  mi;
   logic [TmrW-1:0] cnt_nx;
   logic [3:0]  up_idx;

   assign rsp_last  = idx_ff == last_idx_ff;
   assign rsp_fire  = buf_vld_ff && rsp_ready;
   assign proc      = in_vld_ff && (!buf_vld_ff || (rsp_ready && rsp_last));
   assign req_ready = !in_vld_ff || proc;
   assign mi        = in_ff.mod_index;

   // event evaluation
   always_comb begin
      mod_state_in   = mod_state_ff;
      lp_fired_in    = lp_fired_ff;
      hold_cnt_in    = hold_cnt_ff;
      hold_run_in    = hold_run_ff;
      exp_cnt_in     = exp_cnt_ff;
      exp_run_in     = exp_run_ff;
      rpt_base_in    = rpt_base_ff;
      rpt_shf_in     = rpt_shf_ff;
      rpt_fn_in      = rpt_fn_ff;
      rpt_run_in     = rpt_run_ff;
      rpt_started_in = rpt_started_ff;
      rpt_cnt_in     = rpt_cnt_ff;
      tap            = 1'b0;
      tap_base       = in_ff.sym_code;
      tap_shf        = in_ff.shifted_code;
      tap_fn         = in_ff.fn_code;
      status_in      = 1'b0;
      changed_in     = 1'b0;
      from_rep_in    = 1'b0;
      cnt_nx         = '0;
      case (in_ff.mode)
         ModePress: begin
            if (in_ff.key_kind == KindModifier && mi < 3'(NumMods)) begin
               lp_fired_in[mi] = 1'b0;
               hold_cnt_in[mi] = '0;
               hold_run_in[mi] = 1'b1;
            end else if (in_ff.key_kind == KindChar) begin
               tap = 1'b1;
               if (in_ff.repeat_enable) begin
                  rpt_base_in    = in_ff.sym_code;
                  rpt_shf_in     = in_ff.shifted_code;
                  rpt_fn_in      = in_ff.fn_code;
                  rpt_started_in = 1'b0;
                  rpt_run_in     = 1'b1;
                  rpt_cnt_in     = '0;
               end
            end
         end
         ModeRelease: begin
            if (in_ff.key_kind == KindModifier && mi < 3'(NumMods)) begin
               hold_run_in[mi] = 1'b0;
               if (lp_fired_ff[mi]) begin
                  lp_fired_in[mi] = 1'b0;
               end else begin
                  if (mod_state_ff[mi] == ModOff) begin
                     mod_state_in[mi] = ModOneShot;
                     if (sticky_to_ff != 16'd0) begin
                        exp_cnt_in[mi] = '0;
                        exp_run_in[mi] = 1'b1;
                     end
                  end else if (mod_state_ff[mi] == ModOneShot) begin
                     mod_state_in[mi] = ModLocked;
                     exp_run_in[mi]   = 1'b0;
                  end else begin
                     mod_state_in[mi] = ModOff;
                  end
                  changed_in = 1'b1;
                  status_in  = 1'b1;
               end
            end else if (in_ff.key_kind == KindChar) begin
               if (in_ff.sym_code == rpt_base_ff && in_ff.shifted_code == rpt_shf_ff
                   && in_ff.fn_code == rpt_fn_ff) begin
                  rpt_run_in     = 1'b0;
                  rpt_started_in = 1'b0;
               end
            end
         end
         ModeTick: begin
            // per modifier: hold timer first, then expiry timer
            for (int i = 0; i < NumMods; i++) begin
               if (hold_run_ff[i]) begin
                  hold_cnt_in[i] = tmr_inc(hold_cnt_ff[i]);
                  if (hold_cnt_in[i] >= tmr_limit(long_press_ff)) begin
                     hold_run_in[i]  = 1'b0;
                     lp_fired_in[i]  = 1'b1;
                     mod_state_in[i] = (mod_state_ff[i] == ModLocked) ? ModOff : ModLocked;
                     exp_run_in[i]   = 1'b0;
                     changed_in      = 1'b1;
                  end
               end
               if (exp_run_in[i]) begin
                  exp_cnt_in[i] = tmr_inc(exp_cnt_ff[i]);
                  if (exp_cnt_in[i] >= tmr_limit(sticky_to_ff)) begin
                     exp_run_in[i] = 1'b0;
                     if (mod_state_in[i] == ModOneShot) begin
                        mod_state_in[i] = ModOff;
                        changed_in      = 1'b1;
                     end
                  end
               end
            end
            // typematic repeat
            if (rpt_run_ff) begin
               cnt_nx     = tmr_inc(rpt_cnt_ff);
               rpt_cnt_in = cnt_nx;
               if (cnt_nx >= tmr_limit(rpt_started_ff ? rpt_intv_ff : rpt_delay_ff)) begin
                  rpt_cnt_in     = '0;
                  rpt_started_in = 1'b1;
                  from_rep_in    = 1'b1;
                  tap            = 1'b1;
                  tap_base       = rpt_base_ff;
                  tap_shf        = rpt_shf_ff;
                  tap_fn         = rpt_fn_ff;
               end
            end
            status_in = !tap && changed_in;
         end
         default: begin
         end
      endcase

      // tap script: held modifier keysyms in order, then the target
      held_in  = '{default: 32'd0};
      nheld_in = 3'd0;
      target_in = tap_base;
      if (tap) begin
         for (int i = 0; i < NumSyms; i++) begin
            if (mod_state_in[i] != ModOff && mod_sym_ff[i] != 32'd0) begin
               held_in[nheld_in[1:0]] = mod_sym_ff[i];
               nheld_in = nheld_in + 3'd1;
            end
         end
         if (tap_fn != 32'd0 && mod_state_in[FnMod] != ModOff) begin
            target_in = tap_fn;
         end else if (tap_shf != 32'd0 && mod_state_in[ShiftMod] != ModOff) begin
            target_in = tap_shf;
         end
         // one-shot modifiers are spent by the tap
         for (int i = 0; i < NumMods; i++) begin
            if (mod_state_in[i] == ModOneShot) begin
               mod_state_in[i] = ModOff;
               exp_run_in[i]   = 1'b0;
               changed_in      = 1'b1;
            end
         end
      end
      emit        = tap || status_in;
      last_idx_in = tap ? {nheld_in, 1'b0} : 4'd0;
      for (int i = 0; i < NumMods; i++) begin
         states_in[2*i +: 2] = mod_state_in[i];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_sym_ff[0] <= 32'd65505;
         mod_sym_ff[1] <= 32'd65507;
         mod_sym_ff[2] <= 32'd65513;
         mod_sym_ff[3] <= 32'd65515;
         long_press_ff <= 16'd500;
         sticky_to_ff  <= 16'd0;
         rpt_delay_ff  <= 16'd600;
         rpt_intv_ff   <= 16'd40;
      end else if (csr_write_en) begin
         case (csr_index)
            CsrShiftSym, CsrControlSym, CsrAltSym, CsrSuperSym: begin
               mod_sym_ff[csr_index[1:0]] <= csr_wdata;
            end
            CsrLongPress: long_press_ff <= csr_wdata[15:0];
            CsrStickyTo:  sticky_to_ff  <= csr_wdata[15:0];
            CsrRptDelay:  rpt_delay_ff  <= csr_wdata[15:0];
            CsrRptIntv:   rpt_intv_ff   <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // modifier and repeat state
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_state_ff   <= '{default: ModOff};
         lp_fired_ff    <= '{default: 1'b0};
         hold_cnt_ff    <= '{default: '0};
         hold_run_ff    <= '{default: 1'b0};
         exp_cnt_ff     <= '{default: '0};
         exp_run_ff     <= '{default: 1'b0};
         rpt_base_ff    <= 32'd0;
         rpt_shf_ff     <= 32'd0;
         rpt_fn_ff      <= 32'd0;
         rpt_run_ff     <= 1'b0;
         rpt_started_ff <= 1'b0;
         rpt_cnt_ff     <= '0;
      end else if (proc) begin
         mod_state_ff   <= mod_state_in;
         lp_fired_ff    <= lp_fired_in;
         hold_cnt_ff    <= hold_cnt_in;
         hold_run_ff    <= hold_run_in;
         exp_cnt_ff     <= exp_cnt_in;
         exp_run_ff     <= exp_run_in;
         rpt_base_ff    <= rpt_base_in;
         rpt_shf_ff     <= rpt_shf_in;
         rpt_fn_ff      <= rpt_fn_in;
         rpt_run_ff     <= rpt_run_in;
         rpt_started_ff <= rpt_started_in;
         rpt_cnt_ff     <= rpt_cnt_in;
      end
   end

   // input register control
   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (proc) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // script buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff <= 1'b0;
         idx_ff     <= 4'd0;
      end else if (proc) begin
         buf_vld_ff <= emit;
         idx_ff     <= 4'd0;
      end else if (rsp_fire) begin
         if (rsp_last) begin
            buf_vld_ff <= 1'b0;
         end
         idx_ff <= idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && emit) begin
         held_ff     <= held_in;
         nheld_ff    <= nheld_in;
         target_ff   <= target_in;
         last_idx_ff <= last_idx_in;
         status_ff   <= status_in;
         changed_ff  <= changed_in;
         states_ff   <= states_in;
         from_rep_ff <= from_rep_in;
      end
   end

   // result word: a status word, or downs, tap, ups in reverse
   assign up_idx    = {nheld_ff, 1'b0} - idx_ff;
   assign rsp_valid = buf_vld_ff;

   always_comb begin
      rsp_data.state_changed   = changed_ff;
      rsp_data.modifier_states = states_ff;
      rsp_data.from_repeat     = from_rep_ff;
      rsp_data.last            = rsp_last;
      if (status_ff) begin
         rsp_data.action_kind = ActStatus;
         rsp_data.keysym      = 32'd0;
      end else if (idx_ff < {1'b0, nheld_ff}) begin
         rsp_data.action_kind = ActDown;
         rsp_data.keysym      = held_ff[idx_ff[1:0]];
      end else if (idx_ff == {1'b0, nheld_ff}) begin
         rsp_data.action_kind = ActTap;
         rsp_data.keysym      = target_ff;
      end else begin
         rsp_data.action_kind = ActUp;
         rsp_data.keysym      = held_ff[up_idx[1:0]];
      end
   end

endmodule

[test/smkr_script_check_pkg.sv]
// ----------------------------------------------------------------------------
// smkr_script_check_pkg
// Scoreboard for the sticky modifier / key repeat core. It keeps its own copy
// of the registers, modifier timers and repeat key, works out the down, tap,
// up and status words that each accepted event word causes, and checks the
// result words against them in order.
// ----------------------------------------------------------------------------
package smkr_script_check_pkg;
   import smkr_pkg::*;

   class key_script_scoreboard;
      // register copies
      logic [31:0]  mod_keysym [NumSyms];
      logic [15:0]  long_press;
      logic [15:0]  sticky_timeout;
      logic [15:0]  repeat_delay;
      logic [15:0]  repeat_interval;

      // per modifier state and timers
      logic [1:0]   mod_state [NumMods];
      bit           long_fired [NumMods];
      logic [15:0]  hold_ticks [NumMods];
      bit           hold_on [NumMods];
      logic [15:0]  expiry_ticks [NumMods];
      bit           expiry_on [NumMods];

      // repeating key
      logic [31:0]  rpt_sym;
      logic [31:0]  rpt_shifted;
      logic [31:0]  rpt_fn;
      bit           rpt_on;
      bit           rpt_started;
      logic [15:0]  rpt_ticks;

      rsp_word_type expected_words [$];
      rsp_word_type script [$];        // words of the event being worked out
      bit           mods_changed;
      int           failures;

      function new();
         failures = 0;
         clear();
      endfunction

      function void clear();
         mod_keysym      = '{32'd65505, 32'd65507, 32'd65513, 32'd65515};
         long_press      = 16'd500;
         sticky_timeout  = 16'd0;
         repeat_delay    = 16'd600;
         repeat_interval = 16'd40;
         for (int i = 0; i < NumMods; i++) begin
            mod_state[i]    = ModOff;
            long_fired[i]   = 1'b0;
            hold_ticks[i]   = '0;
            hold_on[i]      = 1'b0;
            expiry_ticks[i] = '0;
            expiry_on[i]    = 1'b0;
         end
         rpt_sym     = '0;
         rpt_shifted = '0;
         rpt_fn      = '0;
         rpt_on      = 1'b0;
         rpt_started = 1'b0;
         rpt_ticks   = '0;
         expected_words.delete();
      endfunction

      function void write_reg(logic [2:0] index, logic [31:0] value);
         case (index)
            CsrShiftSym, CsrControlSym, CsrAltSym, CsrSuperSym: begin
               mod_keysym[index[1:0]] = value;
            end
            CsrLongPress: long_press      = value[15:0];
            CsrStickyTo:  sticky_timeout  = value[15:0];
            CsrRptDelay:  repeat_delay    = value[15:0];
            CsrRptIntv:   repeat_interval = value[15:0];
            default: ;
         endcase
      endfunction

      // saturating tick counter and its limit test (a zero limit acts as one)
      function logic [15:0] bump(logic [15:0] count);
         return (count == 16'hFFFF) ? count : count + 16'd1;
      endfunction

      function bit reached(logic [15:0] count, logic [15:0] lim);
         return count >= ((lim == 16'd0) ? 16'd1 : lim);
      endfunction

      function void add_word(logic [1:0] act, logic [31:0] sym);
         rsp_word_type w;
         w             = '0;
         w.action_kind = act;
         w.keysym      = sym;
         script.push_back(w);
      endfunction

      // downs of held modifiers, the tap, the ups in reverse; one-shots clear
      function void tap_script(logic [31:0] base, logic [31:0] shifted, logic [31:0] fnc);
         logic [31:0] held [$];
         logic [31:0] target;
         target = base;
         for (int i = 0; i < NumSyms; i++) begin
            if (mod_state[i] != ModOff && mod_keysym[i] != 32'd0) held.push_back(mod_keysym[i]);
         end
         if (fnc != 32'd0 && mod_state[FnMod] != ModOff) target = fnc;
         else if (shifted != 32'd0 && mod_state[ShiftMod] != ModOff) target = shifted;
         foreach (held[i]) add_word(ActDown, held[i]);
         add_word(ActTap, target);
         for (int i = held.size() - 1; i >= 0; i--) add_word(ActUp, held[i]);
         for (int i = 0; i < NumMods; i++) begin
            if (mod_state[i] == ModOneShot) begin
               mod_state[i] = ModOff;
               expiry_on[i] = 1'b0;
               mods_changed = 1'b1;
            end
         end
      endfunction

      // work out the words of one accepted event and queue them
      function void predict_script(req_word_type ev);
         bit           show_status;
         bit           by_repeat;
         logic [9:0]   states;
         int           m;
         rsp_word_type w;
         show_status  = 1'b0;
         by_repeat    = 1'b0;
         mods_changed = 1'b0;
         script.delete();
         m = int'(ev.mod_index);
         case (ev.mode)
            ModePress: begin
               if (ev.key_kind == KindModifier && m < NumMods) begin
                  long_fired[m] = 1'b0;
                  hold_ticks[m] = '0;
                  hold_on[m]    = 1'b1;
               end else if (ev.key_kind == KindChar) begin
                  tap_script(ev.sym_code, ev.shifted_code, ev.fn_code);
                  if (ev.repeat_enable) begin
                     rpt_sym     = ev.sym_code;
                     rpt_shifted = ev.shifted_code;
                     rpt_fn      = ev.fn_code;
                     rpt_started = 1'b0;
                     rpt_on      = 1'b1;
                     rpt_ticks   = '0;
                  end
               end
            end
            ModeRelease: begin
               if (ev.key_kind == KindModifier && m < NumMods) begin
                  hold_on[m] = 1'b0;
                  if (long_fired[m]) begin
                     long_fired[m] = 1'b0;
                  end else begin
                     case (mod_state[m])
                        ModOff: begin
                           mod_state[m] = ModOneShot;
                           if (sticky_timeout != 16'd0) begin
                              expiry_ticks[m] = '0;
                              expiry_on[m]    = 1'b1;
                           end
                        end
                        ModOneShot: begin
                           mod_state[m] = ModLocked;
                           expiry_on[m] = 1'b0;
                        end
                        default: mod_state[m] = ModOff;
                     endcase
                     mods_changed = 1'b1;
                     show_status  = 1'b1;
                  end
               end else if (ev.key_kind == KindChar) begin
                  // only the exact stored key stops the repeat
                  if (ev.sym_code == rpt_sym && ev.shifted_code == rpt_shifted &&
                      ev.fn_code == rpt_fn) begin
                     rpt_on      = 1'b0;
                     rpt_started = 1'b0;
                  end
               end
            end
            ModeTick: begin
               // long-press timers toggle the lock
               for (int i = 0; i < NumMods; i++) begin
                  if (hold_on[i]) begin
                     hold_ticks[i] = bump(hold_ticks[i]);
                     if (reached(hold_ticks[i], long_press)) begin
                        hold_on[i]    = 1'b0;
                        long_fired[i] = 1'b1;
                        mod_state[i]  = (mod_state[i] == ModLocked) ? ModOff : ModLocked;
                        expiry_on[i]  = 1'b0;
                        mods_changed  = 1'b1;
                     end
                  end
               end
               // one-shot expiry
               for (int i = 0; i < NumMods; i++) begin
                  if (expiry_on[i]) begin
                     expiry_ticks[i] = bump(expiry_ticks[i]);
                     if (reached(expiry_ticks[i], sticky_timeout)) begin
                        expiry_on[i] = 1'b0;
                        if (mod_state[i] == ModOneShot) begin
                           mod_state[i] = ModOff;
                           mods_changed = 1'b1;
                        end
                     end
                  end
               end
               // typematic repeat: delay first, then interval
               if (rpt_on) begin
                  rpt_ticks = bump(rpt_ticks);
                  if (reached(rpt_ticks, rpt_started ? repeat_interval : repeat_delay)) begin
                     rpt_ticks   = '0;
                     rpt_started = 1'b1;
                     by_repeat   = 1'b1;
                     tap_script(rpt_sym, rpt_shifted, rpt_fn);
                  end
               end
               if (script.size() == 0 && mods_changed) show_status = 1'b1;
            end
            default: ;
         endcase

         if (show_status && script.size() == 0) add_word(ActStatus, 32'd0);
         states = '0;
         for (int i = 0; i < NumMods; i++) states[2*i +: 2] = mod_state[i];
         foreach (script[i]) begin
            w                 = script[i];
            w.state_changed   = mods_changed;
            w.modifier_states = states;
            w.from_repeat     = by_repeat;
            w.last            = (i == script.size() - 1);
            expected_words.push_back(w);
         end
      endfunction

      task report(string what);
         failures++;
         $display("mismatch: %s", what);
      endtask

      task check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("word %h with nothing expected", got));
            return;
         end
         want = expected_words.pop_front();
         if (got.action_kind !== want.action_kind)
            report($sformatf("action_kind exp %0d got %0d", want.action_kind, got.action_kind));
         if (got.keysym !== want.keysym)
            report($sformatf("keysym exp %h got %h", want.keysym, got.keysym));
         if (got.state_changed !== want.state_changed)
            report($sformatf("state_changed exp %b got %b", want.state_changed,
                             got.state_changed));
         if (got.modifier_states !== want.modifier_states)
            report($sformatf("modifier_states exp %h got %h", want.modifier_states,
                             got.modifier_states));
         if (got.from_repeat !== want.from_repeat)
            report($sformatf("from_repeat exp %b got %b", want.from_repeat, got.from_repeat));
         if (got.last !== want.last)
            report($sformatf("last exp %b got %b", want.last, got.last));
      endtask

      function int pending();
         return expected_words.size();
      endfunction
   endclass

endpackage

[test/sticky_modifier_key_repeat_core_tb.sv]
// ----------------------------------------------------------------------------
// sticky_modifier_key_repeat_core_tb
// Drives press, release and tick event words into the core under several
// register settings: a directed pass over the modifier cycle, fn and shift
// selection, long press, one-shot expiry and typematic repeat, then random
// sequences of modifier taps, holds, character keys, tick bursts and noise.
// Both channels idle and stall in random bursts, but not in the final stretch;
// every result word is checked in order against the scoreboard.
// ----------------------------------------------------------------------------
module sticky_modifier_key_repeat_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smkr_pkg::*;
   import smkr_script_check_pkg::*;

   localparam int         CycleLimit = 400000;
   localparam logic [1:0] ModeUnused = 2'd3;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_data;
   logic         csr_write_en;
   logic [2:0]   csr_index;
   logic [31:0]  csr_wdata;

   key_script_scoreboard sb;
   bit                   calm;          // no idling on either side
   int                   stall_left;
   int                   events_sent;
   int                   hold_hint;     // ticks that make a long press
   int                   cycle_count;
   logic [31:0]          rep_sym, rep_shifted, rep_fn;

   sticky_modifier_key_repeat_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   // result side: random stall bursts unless calm
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(1, 13) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // note accepted events and check accepted words, in one process
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.predict_script(req_data);
         if (rsp_valid && rsp_ready) sb.check_word(rsp_data);
      end
   end

   // run limit
   initial begin
      for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clock);
      $display("sticky_modifier_key_repeat_core_tb NOT OK");
      $finish;
   end

   function automatic logic [31:0] rand_code();
      case ($urandom_range(0, 7))
         0, 1:    return 32'd0;
         2:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // all fields random; callers overwrite the ones that matter
   function automatic req_word_type random_word();
      req_word_type w;
      w.mode          = 2'($urandom_range(0, 3));
      w.key_kind      = 2'($urandom_range(0, 3));
      w.mod_index     = 3'($urandom_range(0, 7));
      w.sym_code      = rand_code();
      w.shifted_code  = rand_code();
      w.fn_code       = rand_code();
      w.repeat_enable = 1'($urandom_range(0, 1));
      return w;
   endfunction

   task automatic send_event(input req_word_type ev);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
      events_sent++;
   endtask

   task automatic tick(input int n);
      req_word_type w;
      repeat (n) begin
         w      = random_word();
         w.mode = ModeTick;
         send_event(w);
      end
   endtask

   task automatic mod_event(input logic [1:0] mode, input int idx);
      req_word_type w;
      w           = random_word();
      w.mode      = mode;
      w.key_kind  = KindModifier;
      w.mod_index = 3'(idx);
      send_event(w);
   endtask

   task automatic char_event(input logic [1:0] mode, input logic [31:0] sym,
                             input logic [31:0] shf, input logic [31:0] fnc,
                             input logic rep);
      req_word_type w;
      w               = random_word();
      w.mode          = mode;
      w.key_kind      = KindChar;
      w.sym_code      = sym;
      w.shifted_code  = shf;
      w.fn_code       = fnc;
      w.repeat_enable = rep;
      if (mode == ModePress && rep) begin
         rep_sym     = sym;
         rep_shifted = shf;
         rep_fn      = fnc;
      end
      send_event(w);
   endtask

   task automatic other_event(input logic [1:0] mode, input logic [1:0] kind,
                              input logic [2:0] idx);
      req_word_type w;
      w           = random_word();
      w.mode      = mode;
      w.key_kind  = kind;
      w.mod_index = idx;
      send_event(w);
   endtask

   // let the block drain completely
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [31:0] shift_s, input logic [31:0] ctrl_s,
                               input logic [31:0] alt_s, input logic [31:0] super_s,
                               input logic [31:0] long_t, input logic [31:0] sticky_t,
                               input logic [31:0] delay_t, input logic [31:0] intv_t);
      settle();
      write_csr(CsrShiftSym, shift_s);
      write_csr(CsrControlSym, ctrl_s);
      write_csr(CsrAltSym, alt_s);
      write_csr(CsrSuperSym, super_s);
      write_csr(CsrLongPress, long_t);
      write_csr(CsrStickyTo, sticky_t);
      write_csr(CsrRptDelay, delay_t);
      write_csr(CsrRptIntv, intv_t);
      csr_write_en <= 1'b0;
      hold_hint = int'(long_t[15:0]);
   endtask

   // random sequences, mostly well formed, some noise
   task automatic run_random(input int n);
      int          stop;
      int          mi;
      logic        rep;
      logic [31:0] s, sh, f;
      stop = events_sent + n;
      while (events_sent < stop) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               repeat ($urandom_range(0, 3)) begin
                  mi = $urandom_range(0, NumMods - 1);
                  mod_event(ModePress, mi);
                  mod_event(ModeRelease, mi);
               end
               rep = 1'($urandom_range(0, 1));
               char_event(ModePress, rand_code(), rand_code(), rand_code(), rep);
               if (rep) tick($urandom_range(0, 5));
            end
            3: begin
               // hold around the long-press time
               mi = $urandom_range(0, NumMods - 1);
               mod_event(ModePress, mi);
               tick($urandom_range(0, (hold_hint < 7) ? hold_hint + 1 : 8));
               mod_event(ModeRelease, mi);
            end
            4, 5: tick($urandom_range(1, 6));
            6: begin
               s  = rand_code();
               sh = rand_code();
               f  = rand_code();
               char_event(ModePress, s, sh, f, 1'b1);
               tick($urandom_range(1, 8));
               if ($urandom_range(0, 2) == 0) sh = sh ^ 32'h1;
               char_event(ModeRelease, s, sh, f, 1'($urandom_range(0, 1)));
            end
            7: begin
               if ($urandom_range(0, 1) == 0)
                  char_event(ModeRelease, rep_sym, rep_shifted, rep_fn, 1'b0);
               else
                  char_event(ModeRelease, rand_code(), rand_code(), rand_code(), 1'b0);
            end
            8: send_event(random_word());
            default: begin
               // sender sometimes waits for every word outstanding
               if ($urandom_range(0, 2) == 0) settle();
               mi = $urandom_range(0, NumMods - 1);
               mod_event(ModeRelease, mi);
            end
         endcase
      end
   endtask

   initial begin
      sb           = new();
      calm         = 1'b0;
      events_sent  = 0;
      hold_hint    = 500;
      rep_sym      = '0;
      rep_shifted  = '0;
      rep_fn       = '0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= CsrShiftSym;
      csr_wdata    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: modifier cycle, shift and fn selection
      char_event(ModePress, 32'h61, 32'h41, 32'd0, 1'b0);
      mod_event(ModeRelease, ShiftMod);
      mod_event(ModeRelease, 1);
      char_event(ModePress, 32'h62, 32'h42, 32'd0, 1'b0);
      mod_event(ModeRelease, FnMod);
      char_event(ModePress, '1, 32'd0, '1, 1'b0);
      mod_event(ModeRelease, 2);
      mod_event(ModeRelease, 2);
      char_event(ModePress, 32'd0, '1, 32'd0, 1'b0);
      mod_event(ModeRelease, 2);
      // ignored events
      other_event(ModeUnused, KindChar, 3'd0);
      other_event(ModePress, KindAction, 3'd0);
      other_event(ModeRelease, KindModifier, 3'd7);

      // short timers: long press, repeat, expiry
      program_regs(32'd65505, 32'd65507, 32'd65513, 32'd65515, 32'd2, 32'd3, 32'd2, 32'd1);
      mod_event(ModePress, ShiftMod);
      tick(2);
      mod_event(ModeRelease, ShiftMod);
      char_event(ModePress, 32'h61, 32'h41, 32'd0, 1'b1);
      tick(3);
      char_event(ModeRelease, 32'h61, 32'h42, 32'd0, 1'b0);
      tick(1);
      char_event(ModeRelease, 32'h61, 32'h41, 32'd0, 1'b0);
      mod_event(ModeRelease, 3);
      tick(3);

      program_regs($urandom(), $urandom(), $urandom(), $urandom(),
                   32'd3, 32'd4, 32'd3, 32'd2);
      run_random(25);

      // lowest timer values, keysyms at their extremes
      program_regs(32'd0, '1, 32'd0, '1, 32'd1, 32'd0, 32'd1, 32'd1);
      run_random(25);

      // highest timer values, upper data bits set
      program_regs('1, 32'd0, $urandom(), 32'd0, '1, '1, '1, '1);
      run_random(15);

      // final stretch without idling
      program_regs($urandom(), $urandom(), rand_code(), rand_code(),
                   {16'($urandom()), 16'($urandom_range(1, 5))},
                   {16'($urandom()), 16'($urandom_range(0, 5))},
                   {16'($urandom()), 16'($urandom_range(1, 5))},
                   {16'($urandom()), 16'($urandom_range(1, 3))});
      calm = 1'b1;
      run_random(25);

      settle();
      repeat (20) @(posedge clock);
      if (sb.failures == 0)
         $display("sticky_modifier_key_repeat_core_tb OK");
      else
         $display("sticky_modifier_key_repeat_core_tb NOT OK");
      $finish;
   end

endmodule

[files.f]
rtl/core/smkr_pkg.sv
rtl/core/sticky_modifier_key_repeat_core.sv
test/smkr_script_check_pkg.sv
test/sticky_modifier_key_repeat_core_tb.sv
